>>> rtl/lhc_pkg.sv
// Package for the latency histogram collector: constants, opcodes, shared types.
// No dependencies.
package lhc_pkg;

    localparam int NumBinsDefault    = 1024;
    localparam int NumCpusDefault    = 4;
    localparam int CountWidthDefault = 32;
    localparam int NumKinds          = 3;
    localparam int CpuW              = 3;
    localparam int KindW             = 2;
    localparam int BinW              = 10;
    localparam int LatW              = 32;
    localparam int SumW              = 64;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_STATS  = 2'd2,
        OP_BIN    = 2'd3
    } t_opcode;

    localparam logic RES_STATS = 1'b0;
    localparam logic RES_BIN   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_DIV,
        ST_OUT
    } t_state;

    // Command passed from the front end to the back end.
    typedef struct packed {
        t_opcode           op;
        logic [KindW-1:0]  kind;
        logic [CpuW-1:0]   cpu;
        logic [LatW-1:0]   lat;
        logic [BinW-1:0]   bin;
    } t_cmd;

    typedef struct packed {
        logic              result_kind;
        logic [LatW-1:0]   min_latency;
        logic [LatW-1:0]   max_latency;
        logic [LatW-1:0]   sample_total;
        logic [LatW-1:0]   overflow_total;
        logic [LatW-1:0]   average_latency;
        logic              average_valid;
        logic [LatW-1:0]   bin_count;
    } t_result;

endpackage

>>> rtl/lhc_if.sv
// Valid/ready channel interfaces for the latency histogram collector.
// Depends on lhc_pkg.
interface lhc_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               opcode;
    logic [lhc_pkg::KindW-1:0] hist_kind;
    logic [lhc_pkg::CpuW-1:0]  cpu_index;
    logic [lhc_pkg::LatW-1:0]  latency_us;
    logic [lhc_pkg::BinW-1:0]  bin_index;
    modport source (output valid, opcode, hist_kind, cpu_index, latency_us, bin_index,
                    input ready);
    modport sink   (input valid, opcode, hist_kind, cpu_index, latency_us, bin_index,
                    output ready);
endinterface

interface lhc_out_if;
    logic                     valid;
    logic                     ready;
    logic                     result_kind;
    logic [lhc_pkg::LatW-1:0] min_latency;
    logic [lhc_pkg::LatW-1:0] max_latency;
    logic [lhc_pkg::LatW-1:0] sample_total;
    logic [lhc_pkg::LatW-1:0] overflow_total;
    logic [lhc_pkg::LatW-1:0] average_latency;
    logic                     average_valid;
    logic [lhc_pkg::LatW-1:0] bin_count;
    modport source (output valid, result_kind, min_latency, max_latency, sample_total,
                    overflow_total, average_latency, average_valid, bin_count,
                    input ready);
    modport sink   (input valid, result_kind, min_latency, max_latency, sample_total,
                    overflow_total, average_latency, average_valid, bin_count,
                    output ready);
endinterface

>>> rtl/latency_histogram_collector.sv
// Top level of the latency histogram collector.
// Depends on lhc_pkg, lhc_if, lhc_front, lhc_back, lhc_div.
//
//  channel   dir  handshake        carries
//  in_ch     in   valid/ready      opcode, kind, cpu, latency, bin
//  out_ch    out  valid/ready      statistics or bin count
//  config    in   i_cfg_we         record_enable
//
// Record: the back end reads the bin, then writes it back.
// Read bin: the back end steps through ST_IDLE, ST_RMW and ST_OUT; the result is registered on leaving ST_OUT.
// Read statistics: when the histogram holds samples, the bit-serial 64/32 divider forms the average in ST_DIV.
// Clear: sweeps the NUM_CPUS*NUM_BINS bin words of one kind, one bin word per cycle.
// After reset all 3*NUM_CPUS*NUM_BINS bin words are swept before
// commands drain; the 2-deep queue accepts transactions meanwhile.
// Dropped transactions (invalid kind/cpu, disabled record) are accepted but never queued.
module latency_histogram_collector #(
    parameter int NUM_BINS    = lhc_pkg::NumBinsDefault,
    parameter int NUM_CPUS    = lhc_pkg::NumCpusDefault,
    parameter int COUNT_WIDTH = lhc_pkg::CountWidthDefault
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    lhc_in_if.sink    in_ch,
    lhc_out_if.source out_ch
);
    logic          r_record_enable;
    logic          cmd_valid, cmd_pop;
    lhc_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_enable <= 1'b1;
        end else if (i_cfg_we) begin
            r_record_enable <= i_cfg_wdata;
        end
    end

    lhc_front #(.NUM_CPUS(NUM_CPUS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .in_ch           (in_ch),
        .i_record_enable (r_record_enable),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_pop       (cmd_pop)
    );

    lhc_back #(
        .NUM_BINS    (NUM_BINS),
        .NUM_CPUS    (NUM_CPUS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .out_ch      (out_ch)
    );
endmodule

>>> rtl/lhc_front.sv
// Front end: accepts transactions, drops invalid ones, queues commands.
// Depends on lhc_pkg.
module lhc_front #(
    parameter int NUM_CPUS = lhc_pkg::NumCpusDefault
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lhc_in_if.sink         in_ch,
    input  logic           i_record_enable,
    output logic           o_cmd_valid,
    output lhc_pkg::t_cmd  o_cmd,
    input  logic           i_cmd_pop
);
    localparam int Depth = 2;

    lhc_pkg::t_cmd r_q [Depth];
    logic [1:0]    r_cnt, n_cnt;
    logic          r_rd, r_wr;
    logic          keep, push;
    lhc_pkg::t_cmd cmd;

    assign cmd.op   = lhc_pkg::t_opcode'(in_ch.opcode);
    assign cmd.kind = in_ch.hist_kind;
    assign cmd.cpu  = in_ch.cpu_index;
    assign cmd.lat  = in_ch.latency_us;
    assign cmd.bin  = in_ch.bin_index;

    // Classification: only commands that change state or answer are queued.
    always_comb begin
        keep = 1'b0;
        if (32'(in_ch.hist_kind) < lhc_pkg::NumKinds) begin
            if (cmd.op == lhc_pkg::OP_CLEAR) begin
                keep = 1'b1;
            end else if (32'(in_ch.cpu_index) < NUM_CPUS) begin
                keep = (cmd.op != lhc_pkg::OP_RECORD) || i_record_enable;
            end
        end
    end

    assign in_ch.ready = (r_cnt != 2'(Depth));
    assign push        = in_ch.valid && in_ch.ready && keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_comb begin
        n_cnt = r_cnt + 2'(push) - 2'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) r_wr <= ~r_wr;
            if (i_cmd_pop) r_rd <= ~r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= cmd;
    end
endmodule

>>> rtl/lhc_div.sv
// Radix-2 restoring divider: 64-bit dividend by 32-bit divisor, saturating quotient.
// Depends on lhc_pkg.
module lhc_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [lhc_pkg::SumW-1:0] i_dividend,
    input  logic [lhc_pkg::LatW-1:0] i_divisor,
    output logic                     o_done,
    output logic [lhc_pkg::LatW-1:0] o_quotient
);
    logic [lhc_pkg::SumW-1:0] r_quo;
    logic [lhc_pkg::LatW:0]   r_rem;
    logic [lhc_pkg::LatW-1:0] r_dsr;
    logic [6:0]               r_cnt;
    logic                     r_busy;
    logic [lhc_pkg::LatW:0]   shifted;
    logic                     ge;

    assign shifted = {r_rem[lhc_pkg::LatW-1:0], r_quo[lhc_pkg::SumW-1]};
    assign ge      = shifted >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= !i_start && r_busy && (r_cnt == 7'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? (shifted - {1'b0, r_dsr}) : shifted;
            r_quo <= {r_quo[lhc_pkg::SumW-2:0], ge};
        end
    end

    assign o_quotient = (r_quo[lhc_pkg::SumW-1:lhc_pkg::LatW] != '0) ? '1
                      : r_quo[lhc_pkg::LatW-1:0];
endmodule

>>> rtl/lhc_back.sv
// Back end: bin memory, per-histogram statistics, clear sweep, result register.
// Depends on lhc_pkg and lhc_div.
module lhc_back #(
    parameter int NUM_BINS    = lhc_pkg::NumBinsDefault,
    parameter int NUM_CPUS    = lhc_pkg::NumCpusDefault,
    parameter int COUNT_WIDTH = lhc_pkg::CountWidthDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  lhc_pkg::t_cmd   i_cmd,
    output logic            o_cmd_pop,
    lhc_out_if.source       out_ch
);
    localparam int NumHists  = lhc_pkg::NumKinds * NUM_CPUS;
    localparam int HistW     = $clog2(NumHists);
    localparam int IdxW      = $clog2(NUM_BINS);
    localparam int AddrW     = HistW + IdxW;
    localparam int Depth     = NumHists * NUM_BINS;
    localparam int CountBits = (COUNT_WIDTH >= 32) ? 32 : COUNT_WIDTH;
    localparam logic [31:0] CountMax = 32'((64'd1 << CountBits) - 64'd1);
    localparam logic [31:0] MinReset = 32'hFFFF_FFFF;

    // Bin memory, address = hist * NUM_BINS + bin, equal to hist concatenated
    // with bin when NUM_BINS is a power of two; general form used here.
    logic [31:0] r_mem [Depth];
    logic [31:0] r_rdata;

    logic [31:0] r_min [NumHists];
    logic [31:0] r_max [NumHists];
    logic [31:0] r_ovf [NumHists];
    logic [31:0] r_tot [NumHists];
    logic [63:0] r_sum [NumHists];

    lhc_pkg::t_state r_state, n_state;
    logic [AddrW-1:0] r_clr_addr;
    logic [AddrW-1:0] r_clr_end;
    logic [AddrW-1:0] addr;
    logic [HistW-1:0] hist;
    logic             in_range;
    logic             r_out_valid;
    lhc_pkg::t_result r_res;
    logic             div_start, div_done;
    logic [31:0]      div_q;
    logic             mem_we;
    logic [AddrW-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic [AddrW-1:0] kind_base;

    assign hist      = HistW'(i_cmd.kind * NUM_CPUS + i_cmd.cpu);
    assign in_range  = (i_cmd.op == lhc_pkg::OP_RECORD) ? (i_cmd.lat < 32'(NUM_BINS))
                     : (32'(i_cmd.bin) < NUM_BINS);
    assign addr      = AddrW'(hist * NUM_BINS) + (i_cmd.op == lhc_pkg::OP_RECORD
                     ? AddrW'(i_cmd.lat[IdxW-1:0]) : AddrW'(i_cmd.bin));
    assign kind_base = AddrW'(i_cmd.kind * NUM_CPUS * NUM_BINS);

    lhc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum[hist]),
        .i_divisor  (r_tot[hist]),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        div_start = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = '0;
        case (r_state)
            lhc_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr_addr == r_clr_end) begin
                    n_state   = lhc_pkg::ST_IDLE;
                    o_cmd_pop = i_cmd_valid && (i_cmd.op == lhc_pkg::OP_CLEAR);
                end
            end
            lhc_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == lhc_pkg::OP_CLEAR) begin
                        n_state = lhc_pkg::ST_CLEAR;
                    end else if (!r_out_valid || out_ch.ready) begin
                        n_state = lhc_pkg::ST_RMW;
                    end
                end
            end
            lhc_pkg::ST_RMW: begin
                if (i_cmd.op == lhc_pkg::OP_RECORD) begin
                    mem_we    = in_range;
                    mem_waddr = addr;
                    mem_wdata = (r_rdata >= CountMax) ? CountMax : r_rdata + 32'd1;
                    o_cmd_pop = 1'b1;
                    n_state   = lhc_pkg::ST_IDLE;
                end else if (i_cmd.op == lhc_pkg::OP_STATS && r_tot[hist] != '0) begin
                    div_start = 1'b1;
                    n_state   = lhc_pkg::ST_DIV;
                end else begin
                    n_state = lhc_pkg::ST_OUT;
                end
            end
            lhc_pkg::ST_DIV: begin
                if (div_done) n_state = lhc_pkg::ST_OUT;
            end
            lhc_pkg::ST_OUT: begin
                if (!r_out_valid || out_ch.ready) begin
                    o_cmd_pop = 1'b1;
                    n_state   = lhc_pkg::ST_IDLE;
                end
            end
            default: n_state = lhc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lhc_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_end   <= AddrW'(Depth - 1);
            r_out_valid <= 1'b0;
            for (int h = 0; h < NumHists; h++) begin
                r_min[h] <= MinReset;
                r_max[h] <= '0;
                r_ovf[h] <= '0;
                r_tot[h] <= '0;
                r_sum[h] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == lhc_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AddrW'(1);
            end
            if (r_state == lhc_pkg::ST_IDLE && n_state == lhc_pkg::ST_CLEAR) begin
                r_clr_addr <= kind_base;
                r_clr_end  <= kind_base + AddrW'(NUM_CPUS * NUM_BINS - 1);
                for (int c = 0; c < NUM_CPUS; c++) begin
                    r_min[HistW'(i_cmd.kind * NUM_CPUS + c)] <= MinReset;
                    r_max[HistW'(i_cmd.kind * NUM_CPUS + c)] <= '0;
                    r_ovf[HistW'(i_cmd.kind * NUM_CPUS + c)] <= '0;
                    r_tot[HistW'(i_cmd.kind * NUM_CPUS + c)] <= '0;
                    r_sum[HistW'(i_cmd.kind * NUM_CPUS + c)] <= '0;
                end
            end
            if (r_state == lhc_pkg::ST_RMW && i_cmd.op == lhc_pkg::OP_RECORD) begin
                if (!in_range) begin
                    r_ovf[hist] <= (r_ovf[hist] >= CountMax) ? CountMax
                                 : r_ovf[hist] + 32'd1;
                end
                if (i_cmd.lat < r_min[hist]) r_min[hist] <= i_cmd.lat;
                if (i_cmd.lat > r_max[hist]) r_max[hist] <= i_cmd.lat;
                r_tot[hist] <= (r_tot[hist] >= CountMax) ? CountMax : r_tot[hist] + 32'd1;
                r_sum[hist] <= r_sum[hist] + 64'(i_cmd.lat);
            end
            if (r_state == lhc_pkg::ST_OUT && n_state == lhc_pkg::ST_IDLE) begin
                r_out_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lhc_pkg::ST_OUT && n_state == lhc_pkg::ST_IDLE) begin
            if (i_cmd.op == lhc_pkg::OP_STATS) begin
                r_res <= '{result_kind:     lhc_pkg::RES_STATS,
                           min_latency:     r_min[hist],
                           max_latency:     r_max[hist],
                           sample_total:    r_tot[hist],
                           overflow_total:  r_ovf[hist],
                           average_latency: (r_tot[hist] != '0) ? div_q : '0,
                           average_valid:   (r_tot[hist] != '0),
                           bin_count:       '0};
            end else begin
                r_res <= '{result_kind:     lhc_pkg::RES_BIN,
                           min_latency:     '0,
                           max_latency:     '0,
                           sample_total:    '0,
                           overflow_total:  '0,
                           average_latency: '0,
                           average_valid:   1'b0,
                           bin_count:       in_range ? r_rdata : '0};
            end
        end
    end

    assign out_ch.valid           = r_out_valid;
    assign out_ch.result_kind     = r_res.result_kind;
    assign out_ch.min_latency     = r_res.min_latency;
    assign out_ch.max_latency     = r_res.max_latency;
    assign out_ch.sample_total    = r_res.sample_total;
    assign out_ch.overflow_total  = r_res.overflow_total;
    assign out_ch.average_latency = r_res.average_latency;
    assign out_ch.average_valid   = r_res.average_valid;
    assign out_ch.bin_count       = r_res.bin_count;
endmodule
